FILE: hdl/sdaf_pkg.sv
package sdaf_pkg;

	// format modes
	localparam logic [2:0] MODE_PLAIN = 3'd0;
	localparam logic [2:0] MODE_DECI  = 3'd1;
	localparam logic [2:0] MODE_CENTI = 3'd2;
	localparam logic [2:0] MODE_MILLI = 3'd3;
	localparam logic [2:0] MODE_TWO   = 3'd4;
	localparam logic [2:0] MODE_TIME  = 3'd5;
	localparam logic [2:0] MODE_BOOL  = 3'd6;

	// ASCII codes
	localparam logic [6:0] CH_ZERO  = 7'h30;
	localparam logic [6:0] CH_MINUS = 7'h2D;
	localparam logic [6:0] CH_POINT = 7'h2E;
	localparam logic [6:0] CH_O     = 7'h6F;
	localparam logic [6:0] CH_N     = 7'h6E;
	localparam logic [6:0] CH_F     = 7'h66;

	// decimal digit extraction
	localparam int NUM_DIGITS = 5;
	localparam int DIG_IDX_W  = 3;
	localparam logic [DIG_IDX_W-1:0] LAST_DIGIT = DIG_IDX_W'(NUM_DIGITS - 1);

	// hours = (minutes * HOUR_RECIP) >> HOUR_SHIFT, exact for 0..32767
	localparam logic [15:0] HOUR_RECIP = 16'd34953;
	localparam int          HOUR_SHIFT = 21;

	// character slots, emitted in ascending order; digit i owns three slots
	localparam int SLOT_SIGN   = 0;
	localparam int SLOT_ZERO0  = 1;   // leading zero before point at digit i: 1 + 3i
	localparam int SLOT_POINT0 = 2;   // point before digit i: 2 + 3i
	localparam int SLOT_DIGIT0 = 3;   // digit i: 3 + 3i
	localparam int SLOT_TPOINT = 16;
	localparam int SLOT_MTENS  = 17;
	localparam int SLOT_MONES  = 18;
	localparam int SLOT_BOOL_O = 19;
	localparam int SLOT_BOOL_N = 20;
	localparam int SLOT_BOOL_F = 21;
	localparam int SLOT_BOOL_F2 = 22;
	localparam int NUM_SLOTS   = 23;

	typedef logic [NUM_SLOTS-1:0] slot_mask_t;

	typedef struct packed {
		logic                 load;
		logic                 prep;
		logic                 split;
		logic                 digit;
		logic [DIG_IDX_W-1:0] dig_idx;
		logic                 build;
		logic                 pop;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic mask_last;
	} stat_t;

endpackage

FILE: hdl/sdaf_ctrl.sv
module sdaf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  sdaf_pkg::stat_t st,
	output sdaf_pkg::cmd_t  cmd
);
	import sdaf_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PREP  = 6'b000010,
		ST_SPLIT = 6'b000100,
		ST_DIGIT = 6'b001000,
		ST_BUILD = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	state_t               state_q, state_d;
	logic [DIG_IDX_W-1:0] dig_cnt_q, dig_cnt_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d     = state_q;
		dig_cnt_d   = dig_cnt_q;
		cmd         = '0;
		cmd.dig_idx = dig_cnt_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_SPLIT;
			end
			ST_SPLIT: begin
				cmd.split = 1'b1;
				dig_cnt_d = '0;
				state_d   = ST_DIGIT;
			end
			ST_DIGIT: begin
				cmd.digit = 1'b1;
				if (dig_cnt_q == LAST_DIGIT) begin
					state_d = ST_BUILD;
				end else begin
					dig_cnt_d = dig_cnt_q + 1'b1;
				end
			end
			ST_BUILD: begin
				cmd.build = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				if (st.out_free) begin
					cmd.pop = 1'b1;
					if (st.mask_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			dig_cnt_q <= '0;
		end else begin
			state_q   <= state_d;
			dig_cnt_q <= dig_cnt_d;
		end
	end

endmodule

FILE: hdl/sdaf_dp.sv
module sdaf_dp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic signed [15:0]      value,
	input  logic [2:0]              mode,
	input  sdaf_pkg::cmd_t          cmd,
	output sdaf_pkg::stat_t         st,
	input  logic                    out_stall,
	output logic                    out_valid,
	output logic [6:0]              char_code,
	output logic                    last_char
);
	import sdaf_pkg::*;

	logic [15:0] val_q;
	logic [2:0]  mode_q;
	logic [15:0] num_q;
	logic [30:0] prod_q;
	logic [5:0]  rem_q;
	logic [3:0]  dig_q [NUM_DIGITS];
	slot_mask_t  mask_q;
	logic        out_valid_q;
	logic [6:0]  char_q;
	logic        last_q;

	logic        neg, is_time, is_bool;
	logic [15:0] mag;
	logic [14:0] mins;
	logic [9:0]  hours;
	logic [15:0] rem_full;

	assign neg     = val_q[15];
	assign is_time = (mode_q == MODE_TIME);
	assign is_bool = (mode_q == MODE_BOOL);
	assign mag     = neg ? (~val_q + 16'd1) : val_q;
	assign mins    = neg ? 15'd0 : val_q[14:0];
	assign hours   = prod_q[HOUR_SHIFT +: 10];
	assign rem_full = {1'b0, mins} - ({6'd0, hours} << 6) + ({6'd0, hours} << 2);

	// one decimal digit per step: compare against the nine multiples of 10^(4-k)
	function automatic logic [16:0] pow_at(input logic [DIG_IDX_W-1:0] k);
		case (k)
			3'd0:    pow_at = 17'd10000;
			3'd1:    pow_at = 17'd1000;
			3'd2:    pow_at = 17'd100;
			3'd3:    pow_at = 17'd10;
			default: pow_at = 17'd1;
		endcase
	endfunction

	logic [16:0] pw, thr, sub;
	logic [3:0]  dig;
	always_comb begin
		pw  = pow_at(cmd.dig_idx);
		dig = '0;
		sub = '0;
		for (int m = 1; m < 10; m++) begin
			thr = 17'(pw * 17'(m));
			if ({1'b0, num_q} >= thr) begin
				dig = 4'(m);
				sub = thr;
			end
		end
	end

	// minutes split into tens and ones (minutes below 60)
	logic [2:0] mt;
	logic [5:0] mo;
	always_comb begin
		mt = '0;
		for (int m = 1; m < 6; m++) begin
			if (rem_q >= 6'(10 * m)) begin
				mt = 3'(m);
			end
		end
		mo = rem_q - (6'(mt) << 3) - (6'(mt) << 1);
	end

	// slot enables
	logic [2:0] fm;
	logic       on, pt;
	slot_mask_t en;
	always_comb begin
		fm = is_time ? MODE_TWO : mode_q;
		en = '0;
		on = 1'b0;
		pt = 1'b0;
		if (is_bool) begin
			en[SLOT_BOOL_O] = 1'b1;
			if (val_q != 16'd0) begin
				en[SLOT_BOOL_N] = 1'b1;
			end else begin
				en[SLOT_BOOL_F]  = 1'b1;
				en[SLOT_BOOL_F2] = 1'b1;
			end
		end else begin
			en[SLOT_SIGN] = neg && !is_time;
			for (int i = 0; i < NUM_DIGITS; i++) begin
				pt = (fm == MODE_MILLI && i == 2) || (fm == MODE_CENTI && i == 3) ||
				     (fm == MODE_DECI && i == 4);
				if (pt) begin
					en[SLOT_ZERO0 + 3*i]  = !on;
					en[SLOT_POINT0 + 3*i] = 1'b1;
					on = 1'b1;
				end
				if (dig_q[i] != 4'd0 || on || i == NUM_DIGITS - 1 ||
				    (i == NUM_DIGITS - 2 && fm == MODE_TWO)) begin
					en[SLOT_DIGIT0 + 3*i] = 1'b1;
					on = 1'b1;
				end
			end
			en[SLOT_TPOINT] = is_time;
			en[SLOT_MTENS]  = is_time;
			en[SLOT_MONES]  = is_time;
		end
	end

	// character of each slot
	logic [6:0] ch_tab [NUM_SLOTS];
	always_comb begin
		for (int s = 0; s < NUM_SLOTS; s++) begin
			ch_tab[s] = CH_ZERO;
		end
		ch_tab[SLOT_SIGN] = CH_MINUS;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			ch_tab[SLOT_ZERO0 + 3*i]  = CH_ZERO;
			ch_tab[SLOT_POINT0 + 3*i] = CH_POINT;
			ch_tab[SLOT_DIGIT0 + 3*i] = CH_ZERO + {3'd0, dig_q[i]};
		end
		ch_tab[SLOT_TPOINT]  = CH_POINT;
		ch_tab[SLOT_MTENS]   = CH_ZERO + {4'd0, mt};
		ch_tab[SLOT_MONES]   = CH_ZERO + {1'b0, mo};
		ch_tab[SLOT_BOOL_O]  = CH_O;
		ch_tab[SLOT_BOOL_N]  = CH_N;
		ch_tab[SLOT_BOOL_F]  = CH_F;
		ch_tab[SLOT_BOOL_F2] = CH_F;
	end

	// lowest pending slot goes out next
	slot_mask_t first_oh;
	logic [6:0] next_char;
	assign first_oh = mask_q & (~mask_q + 1'b1);
	always_comb begin
		next_char = '0;
		for (int s = 0; s < NUM_SLOTS; s++) begin
			if (first_oh[s]) begin
				next_char = next_char | ch_tab[s];
			end
		end
	end

	assign st.mask_last = ((mask_q & ~first_oh) == '0);
	assign st.out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q  <= value;
			mode_q <= mode;
		end
		if (cmd.prep) begin
			num_q  <= mag;
			// full 31-bit product, operands widened before the multiply
			prod_q <= {16'd0, mins} * {15'd0, HOUR_RECIP};
		end
		if (cmd.split) begin
			rem_q <= rem_full[5:0];
			if (is_time) begin
				num_q <= {6'd0, hours};
			end
		end
		if (cmd.digit) begin
			dig_q[cmd.dig_idx] <= dig;
			num_q              <= num_q - sub[15:0];
		end
		if (cmd.build) begin
			mask_q <= en;
		end else if (cmd.pop) begin
			mask_q <= mask_q & ~first_oh;
		end
		if (cmd.pop) begin
			char_q <= next_char;
			last_q <= st.mask_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last_char = last_q;

endmodule

FILE: hdl/signed_decimal_ascii_formatter.sv
// Signed decimal ASCII formatter.
// Input channel (in_valid / in_stall): one item is a signed 16-bit value and a
// 3-bit mode (plain, deci, centi, milli, two-digit, time as HH.MM or HHH.MM, bool).
// Output channel (out_valid / out_stall): one ASCII character per item,
// last_char set on the final character of a value's text (1 to 7 characters).
// After an input item is taken, the controller steps through PREP, SPLIT, the
// DIGIT steps and BUILD; EMIT then loads the first character into the output
// register, and then one character per cycle while out_stall is low. The pace of
// values is set by the five steps of the shared digit unit (one decimal digit
// per cycle), the minutes/hours split and the one-character output channel.
// in_stall stays high from the cycle after acceptance until the last character
// has moved into the output register, so the next value is taken while that
// character still waits at the output.
// When the receiver stalls, the output register holds its character and the
// character sequencer waits; nothing is dropped.
// Reset (arst_n low) returns the controller to idle and empties the output
// register; no other state survives between values.
module signed_decimal_ascii_formatter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] value,
	input  logic [2:0]         mode,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [6:0]         char_code,
	output logic               last_char
);
	import sdaf_pkg::*;

	cmd_t  cmd;
	stat_t st;

	// sequencer: load, magnitude and time split, five digit steps, slot build, emit
	sdaf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	// digit unit, slot mask and output register
	sdaf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.mode      (mode),
		.cmd       (cmd),
		.st        (st),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.char_code (char_code),
		.last_char (last_char)
	);

endmodule

FILE: hdl/sdaf_checker.sv
module sdaf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [15:0] value,
	input logic [2:0]  mode,
	input logic        out_valid,
	input logic        out_stall,
	input logic [6:0]  char_code,
	input logic        last_char
);

	// a stalled character holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(char_code) && $stable(last_char))
		else $error("stalled output item changed");

	// only digits, sign, point and the letters of on/off ever leave
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (char_code >= 7'h30 && char_code <= 7'h39) || char_code == 7'h2D ||
		              char_code == 7'h2E || char_code == 7'h6F || char_code == 7'h6E ||
		              char_code == 7'h66)
		else $error("unexpected character code");

	// one value at a time
	a_busy_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken in back-to-back cycles");

	// digit extraction takes its full length before the input can free up
	a_busy_min: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> ##8 in_stall)
		else $error("input freed before formatting finished");

endmodule

bind signed_decimal_ascii_formatter sdaf_checker u_sdaf_checker (.*);
